[sv/qrm_pkg.sv]
// Shared types, constants and sequencer codes of the queue rate meter.
// Used by every other file of the block; depends on nothing.

package qrm_pkg;

	// Field widths.
	localparam int QUEUE_W  = 3;
	localparam int TIME_W   = 64;
	localparam int PKT_W    = 8;
	localparam int BYTES_W  = 24;
	localparam int WINDOW_W = 32;
	localparam int PPS_W    = 32;
	localparam int BPS_W    = 48;
	localparam int TOTAL_W  = 64;
	localparam int WIRE_W   = 25;

	// Configuration registers.
	localparam int PERIOD_W   = 40;
	localparam int OVH_W      = 8;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 64;
	localparam int REG_IDX_W  = 1;

	localparam logic [REG_IDX_W-1:0] REG_UPDATE_PERIOD = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_OVERHEAD      = 1'b1;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 40'd1000000000;
	localparam logic [OVH_W-1:0]    OVH_RESET    = 8'd24;

	// Geometry.
	localparam int QUEUES_DEF = 8;
	localparam int DIV_W      = 64;
	localparam int MUL_W      = 32;

	// Arithmetic constants. The bit rate gain of 8e9 is 1e9 followed by a shift of three.
	localparam logic [MUL_W-1:0] PPS_GAIN    = 32'd800000000;
	localparam logic [MUL_W-1:0] BPS_GAIN    = 32'd1000000000;
	localparam int               BPS_SHIFT   = 3;
	localparam logic [MUL_W-1:0] DIV5_RECIP  = 32'hCCCCCCCD;
	localparam int               DIV5_SHIFT  = 34;

	typedef struct packed {
		logic [PERIOD_W-1:0] update_period_ns;
		logic [OVH_W-1:0]    overhead_bytes;
	} cfg_t;

	typedef struct packed {
		logic [WINDOW_W-1:0] window_packets;
		logic [TIME_W-1:0]   window_start_ns;
		logic [PPS_W-1:0]    smoothed_pps;
		logic [BPS_W-1:0]    last_bps;
		logic [TOTAL_W-1:0]  packet_total;
		logic [TOTAL_W-1:0]  byte_total;
	} slot_entry_t;

	typedef struct packed {
		logic [PPS_W-1:0]   rate_pps;
		logic [BPS_W-1:0]   rate_bps;
		logic [TOTAL_W-1:0] packets_seen;
		logic [TOTAL_W-1:0] bytes_seen;
		logic               rate_updated;
	} out_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_KEEP,
		ST_WIRE,
		ST_PPS_MUL,
		ST_PPS_DIV,
		ST_BPS_MUL,
		ST_BPS_DIV,
		ST_WRITE,
		ST_OUT
	} seq_state_t;

	typedef enum logic [1:0] {
		MUL_KEEP,
		MUL_WIRE,
		MUL_PPS,
		MUL_BPS
	} mul_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     rd_en;
		logic     wr_en;
		logic     div_start;
		logic     out_load;
		mul_sel_t mul_sel;
	} seq_ctrl_t;

endpackage

[sv/qrm_if.sv]
// Valid/ready channel interfaces for batch items and result items.
// Depends on qrm_pkg for the field widths.

interface qrm_in_if;
	logic                        valid;
	logic                        ready;
	logic                        direction;
	logic [qrm_pkg::QUEUE_W-1:0] queue;
	logic [qrm_pkg::TIME_W-1:0]  now_ns;
	logic [qrm_pkg::PKT_W-1:0]   packet_count;
	logic [qrm_pkg::BYTES_W-1:0] batch_bytes;

	modport source (
		output valid, direction, queue, now_ns, packet_count, batch_bytes,
		input  ready
	);
	modport sink (
		input  valid, direction, queue, now_ns, packet_count, batch_bytes,
		output ready
	);
endinterface

interface qrm_out_if;
	logic                        valid;
	logic                        ready;
	logic [qrm_pkg::PPS_W-1:0]   rate_pps;
	logic [qrm_pkg::BPS_W-1:0]   rate_bps;
	logic [qrm_pkg::TOTAL_W-1:0] packets_seen;
	logic [qrm_pkg::TOTAL_W-1:0] bytes_seen;
	logic                        rate_updated;

	modport source (
		output valid, rate_pps, rate_bps, packets_seen, bytes_seen, rate_updated,
		input  ready
	);
	modport sink (
		input  valid, rate_pps, rate_bps, packets_seen, bytes_seen, rate_updated,
		output ready
	);
endinterface

[sv/qrm_apb_regs.sv]
// APB-style configuration registers: update period and per-packet overhead.
// Depends on qrm_pkg for the register codes, widths and reset values.

module qrm_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [qrm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [qrm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [qrm_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output qrm_pkg::cfg_t                  cfg
);

	logic [qrm_pkg::PERIOD_W-1:0]  period_q;
	logic [qrm_pkg::OVH_W-1:0]     ovh_q;
	logic [qrm_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_en;

	// Registers sit on 64-bit words; the low address bits select a byte within one.
	assign reg_idx = paddr[qrm_pkg::APB_ADDR_W-1 -: qrm_pkg::REG_IDX_W];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= qrm_pkg::PERIOD_RESET;
			ovh_q    <= qrm_pkg::OVH_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				qrm_pkg::REG_UPDATE_PERIOD: period_q <= pwdata[qrm_pkg::PERIOD_W-1:0];
				qrm_pkg::REG_OVERHEAD:      ovh_q    <= pwdata[qrm_pkg::OVH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			qrm_pkg::REG_UPDATE_PERIOD:
				prdata = {{(qrm_pkg::APB_DATA_W-qrm_pkg::PERIOD_W){1'b0}}, period_q};
			qrm_pkg::REG_OVERHEAD:
				prdata = {{(qrm_pkg::APB_DATA_W-qrm_pkg::OVH_W){1'b0}}, ovh_q};
			default:
				prdata = '0;
		endcase
	end

	assign cfg.update_period_ns = period_q;
	assign cfg.overhead_bytes   = ovh_q;

endmodule

[sv/qrm_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle, shared by both rate divisions.
// Depends on qrm_pkg for the operand width and the status struct.

module qrm_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [qrm_pkg::DIV_W-1:0] num,
	input  logic [qrm_pkg::DIV_W-1:0] den,
	output logic [qrm_pkg::DIV_W-1:0] quot,
	output qrm_pkg::div_stat_t        stat
);

	localparam int W     = qrm_pkg::DIV_W;
	localparam int CNT_W = $clog2(W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [W:0]       trial;
	logic             fits;

	// Shift the next numerator bit into the partial remainder and try the subtract.
	assign trial = {rem_q, quo_q[W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign quot      = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[sv/qrm_slot_mem.sv]
// Per-slot state memory with one write and one registered read port.
// Valid bits cleared by reset make unwritten slots read as zero. Depends on qrm_pkg.

module qrm_slot_mem #(
	parameter int SLOTS = 2 * qrm_pkg::QUEUES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rd_en,
	input  logic [$clog2(SLOTS)-1:0]           rd_addr,
	output qrm_pkg::slot_entry_t               rd_data,
	input  logic                               wr_en,
	input  logic [$clog2(SLOTS)-1:0]           wr_addr,
	input  qrm_pkg::slot_entry_t               wr_data
);

	qrm_pkg::slot_entry_t slot_mem [SLOTS];
	qrm_pkg::slot_entry_t rd_q;
	logic [SLOTS-1:0]     valid_q;
	logic                 rd_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= slot_mem[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

[sv/queue_rate_meter_core.sv]
// Top level of the queue rate meter: sequencer, shared multiplier and output register.
// Depends on qrm_pkg, qrm_if, qrm_apb_regs, qrm_divider and qrm_slot_mem.

// Meters traffic per direction and queue. Each batch item adds its packets to the
// queue's open window and to its lifetime packet and byte totals; once the window
// age reaches the update period, the item recomputes the smoothed packet rate and the
// bit rate and opens a new window. Every item yields one result item. The block takes
// one item at a time and drops ready until the item's result is in the output register.
// A batch with a queue index out of range goes straight to the output register; one that
// leaves the window open reads, updates and writes back its slot; one that closes it also
// makes two 64-step passes through the shared radix-2 divider and four multiplier steps
// on the shared 32 by 32 multiplier between memory read and write-back. Slot state sits
// in a memory whose entries read as zero after reset, so no clearing pass is needed.

module queue_rate_meter_core #(
	parameter int QUEUES = qrm_pkg::QUEUES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [qrm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [qrm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [qrm_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	qrm_in_if.sink                         batch,
	qrm_out_if.source                      result
);

	localparam int SLOTS  = 2 * QUEUES;
	localparam int SLOT_W = $clog2(SLOTS);

	qrm_pkg::cfg_t        cfg;
	qrm_pkg::seq_state_t  state_q;
	qrm_pkg::seq_state_t  state_next;
	qrm_pkg::seq_ctrl_t   ctrl;
	qrm_pkg::div_stat_t   div_stat;
	qrm_pkg::slot_entry_t rd_data;
	qrm_pkg::slot_entry_t cur_q;
	qrm_pkg::out_item_t   out_q;

	logic [SLOT_W-1:0]              slot_in;
	logic [SLOT_W-1:0]              slot_q;
	logic                           queue_bad;
	logic                           in_acc;
	logic [qrm_pkg::TIME_W-1:0]     now_q;
	logic [qrm_pkg::PKT_W-1:0]      pkts_q;
	logic [qrm_pkg::BYTES_W-1:0]    bytes_q;
	logic [qrm_pkg::TIME_W-1:0]     age_q;
	logic [qrm_pkg::PPS_W-1:0]      kept_q;
	logic [qrm_pkg::WIRE_W-1:0]     wire_q;
	logic                           upd_q;
	logic                           out_valid_q;

	logic [qrm_pkg::TIME_W-1:0]     age;
	logic [qrm_pkg::PERIOD_W-1:0]   period_eff;
	logic                           close_window;
	logic [qrm_pkg::WINDOW_W:0]     wp_sum;
	logic [qrm_pkg::WINDOW_W-1:0]   wp_sat;
	logic [qrm_pkg::MUL_W-1:0]      mul_a;
	logic [qrm_pkg::MUL_W-1:0]      mul_b;
	logic [2*qrm_pkg::MUL_W-1:0]    mul_p;
	logic [qrm_pkg::DIV_W-1:0]      div_num;
	logic [qrm_pkg::DIV_W-1:0]      div_quot;
	logic [qrm_pkg::PPS_W-1:0]      pps_room;
	logic [qrm_pkg::PPS_W-1:0]      pps_new;
	logic [qrm_pkg::BPS_W-1:0]      bps_new;

	qrm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qrm_slot_mem #(
		.SLOTS (SLOTS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ctrl.rd_en),
		.rd_addr (slot_q),
		.rd_data (rd_data),
		.wr_en   (ctrl.wr_en),
		.wr_addr (slot_q),
		.wr_data (cur_q)
	);

	qrm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.div_start),
		.num    (div_num),
		.den    (age_q),
		.quot   (div_quot),
		.stat   (div_stat)
	);

	// Outgoing queues follow the incoming ones in the slot space.
	assign queue_bad = 32'(batch.queue) >= QUEUES;
	assign slot_in   = batch.direction ? SLOT_W'(QUEUES) + SLOT_W'(batch.queue)
	                                   : SLOT_W'(batch.queue);
	assign in_acc    = batch.valid && ctrl.in_ready;

	// Window bookkeeping on the slot state just read.
	assign age          = now_q - rd_data.window_start_ns;
	assign period_eff   = (cfg.update_period_ns == '0) ? qrm_pkg::PERIOD_W'(1)
	                                                   : cfg.update_period_ns;
	assign close_window = age >= {{(qrm_pkg::TIME_W-qrm_pkg::PERIOD_W){1'b0}}, period_eff};
	assign wp_sum       = {1'b0, rd_data.window_packets}
	                    + {{(qrm_pkg::WINDOW_W+1-qrm_pkg::PKT_W){1'b0}}, pkts_q};
	assign wp_sat       = wp_sum[qrm_pkg::WINDOW_W] ? '1 : wp_sum[qrm_pkg::WINDOW_W-1:0];

	// Shared multiplier.
	always_comb begin
		case (ctrl.mul_sel)
			qrm_pkg::MUL_KEEP: begin
				mul_a = cur_q.smoothed_pps;
				mul_b = qrm_pkg::DIV5_RECIP;
			end
			qrm_pkg::MUL_WIRE: begin
				mul_a = {{(qrm_pkg::MUL_W-qrm_pkg::OVH_W){1'b0}}, cfg.overhead_bytes};
				mul_b = {{(qrm_pkg::MUL_W-qrm_pkg::PKT_W){1'b0}}, pkts_q};
			end
			qrm_pkg::MUL_PPS: begin
				mul_a = cur_q.window_packets;
				mul_b = qrm_pkg::PPS_GAIN;
			end
			qrm_pkg::MUL_BPS: begin
				mul_a = {{(qrm_pkg::MUL_W-qrm_pkg::WIRE_W){1'b0}}, wire_q};
				mul_b = qrm_pkg::BPS_GAIN;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p   = {{qrm_pkg::MUL_W{1'b0}}, mul_a} * {{qrm_pkg::MUL_W{1'b0}}, mul_b};
	assign div_num = (ctrl.mul_sel == qrm_pkg::MUL_BPS) ? mul_p << qrm_pkg::BPS_SHIFT : mul_p;

	// The fresh term saturates so that adding the kept fifth never passes the 32-bit limit.
	assign pps_room = '1 - kept_q;
	assign pps_new  = (div_quot > {{(qrm_pkg::DIV_W-qrm_pkg::PPS_W){1'b0}}, pps_room})
	                ? '1 : div_quot[qrm_pkg::PPS_W-1:0] + kept_q;
	assign bps_new  = (|div_quot[qrm_pkg::DIV_W-1:qrm_pkg::BPS_W])
	                ? '1 : div_quot[qrm_pkg::BPS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		case (state_q)
			qrm_pkg::ST_IDLE:
				state_next = in_acc ? (queue_bad ? qrm_pkg::ST_OUT : qrm_pkg::ST_READ)
				                    : qrm_pkg::ST_IDLE;
			qrm_pkg::ST_READ:    state_next = qrm_pkg::ST_EVAL;
			qrm_pkg::ST_EVAL:
				state_next = close_window ? qrm_pkg::ST_KEEP : qrm_pkg::ST_WRITE;
			qrm_pkg::ST_KEEP:    state_next = qrm_pkg::ST_WIRE;
			qrm_pkg::ST_WIRE:    state_next = qrm_pkg::ST_PPS_MUL;
			qrm_pkg::ST_PPS_MUL: state_next = qrm_pkg::ST_PPS_DIV;
			qrm_pkg::ST_PPS_DIV:
				state_next = div_stat.done ? qrm_pkg::ST_BPS_MUL : qrm_pkg::ST_PPS_DIV;
			qrm_pkg::ST_BPS_MUL: state_next = qrm_pkg::ST_BPS_DIV;
			qrm_pkg::ST_BPS_DIV:
				state_next = div_stat.done ? qrm_pkg::ST_WRITE : qrm_pkg::ST_BPS_DIV;
			qrm_pkg::ST_WRITE:   state_next = qrm_pkg::ST_OUT;
			qrm_pkg::ST_OUT:
				state_next = ctrl.out_load ? qrm_pkg::ST_IDLE : qrm_pkg::ST_OUT;
			default:             state_next = qrm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.mul_sel   = qrm_pkg::MUL_KEEP;
		case (state_q)
			qrm_pkg::ST_IDLE:    ctrl.in_ready  = 1'b1;
			qrm_pkg::ST_READ:    ctrl.rd_en     = 1'b1;
			qrm_pkg::ST_KEEP:    ctrl.mul_sel   = qrm_pkg::MUL_KEEP;
			qrm_pkg::ST_WIRE:    ctrl.mul_sel   = qrm_pkg::MUL_WIRE;
			qrm_pkg::ST_PPS_MUL: begin
				ctrl.mul_sel   = qrm_pkg::MUL_PPS;
				ctrl.div_start = 1'b1;
			end
			qrm_pkg::ST_BPS_MUL: begin
				ctrl.mul_sel   = qrm_pkg::MUL_BPS;
				ctrl.div_start = 1'b1;
			end
			qrm_pkg::ST_WRITE:   ctrl.wr_en     = 1'b1;
			qrm_pkg::ST_OUT:     ctrl.out_load  = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	// Item datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			qrm_pkg::ST_IDLE: begin
				if (in_acc) begin
					slot_q  <= slot_in;
					now_q   <= batch.now_ns;
					pkts_q  <= batch.packet_count;
					bytes_q <= batch.batch_bytes;
					cur_q   <= '0;
					upd_q   <= 1'b0;
				end
			end
			qrm_pkg::ST_EVAL: begin
				cur_q.window_packets  <= wp_sat;
				cur_q.window_start_ns <= rd_data.window_start_ns;
				cur_q.smoothed_pps    <= rd_data.smoothed_pps;
				cur_q.last_bps        <= rd_data.last_bps;
				cur_q.packet_total    <= rd_data.packet_total
				    + {{(qrm_pkg::TOTAL_W-qrm_pkg::PKT_W){1'b0}}, pkts_q};
				cur_q.byte_total      <= rd_data.byte_total
				    + {{(qrm_pkg::TOTAL_W-qrm_pkg::BYTES_W){1'b0}}, bytes_q};
				age_q <= age;
				upd_q <= close_window;
			end
			qrm_pkg::ST_KEEP: begin
				kept_q <= qrm_pkg::PPS_W'(mul_p >> qrm_pkg::DIV5_SHIFT);
			end
			qrm_pkg::ST_WIRE: begin
				wire_q <= {1'b0, bytes_q}
				    + {{(qrm_pkg::WIRE_W-2*qrm_pkg::PKT_W){1'b0}}, mul_p[2*qrm_pkg::PKT_W-1:0]};
			end
			qrm_pkg::ST_PPS_DIV: begin
				if (div_stat.done) begin
					cur_q.smoothed_pps <= pps_new;
				end
			end
			qrm_pkg::ST_BPS_DIV: begin
				if (div_stat.done) begin
					cur_q.last_bps        <= bps_new;
					cur_q.window_packets  <= '0;
					cur_q.window_start_ns <= now_q;
				end
			end
			default: ;
		endcase
	end

	// Output register: holds a result item until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			out_q.rate_pps     <= cur_q.smoothed_pps;
			out_q.rate_bps     <= cur_q.last_bps;
			out_q.packets_seen <= cur_q.packet_total;
			out_q.bytes_seen   <= cur_q.byte_total;
			out_q.rate_updated <= upd_q;
		end
	end

	assign batch.ready         = ctrl.in_ready;
	assign result.valid        = out_valid_q;
	assign result.rate_pps     = out_q.rate_pps;
	assign result.rate_bps     = out_q.rate_bps;
	assign result.packets_seen = out_q.packets_seen;
	assign result.bytes_seen   = out_q.bytes_seen;
	assign result.rate_updated = out_q.rate_updated;

endmodule
